/* rtl/mflt_pkg.sv */
package mflt_pkg;

    // Frame phase codes
    localparam logic [1:0] PH_FUNC = 2'd0;
    localparam logic [1:0] PH_META = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADER   = 2'd0;
    localparam logic [1:0] REG_CHECKSUM = 2'd1;
    localparam logic [1:0] REG_MAX      = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    // Function codes with their own frame layout
    localparam logic [7:0] FC_READ_INPUT_REGS   = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE_COIL = 8'd5;
    localparam logic [7:0] FC_WRITE_SINGLE_REG  = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS       = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS        = 8'd16;
    localparam logic [7:0] FC_REPORT_ID         = 8'd17;
    localparam logic [7:0] FC_MASK_WRITE        = 8'd22;
    localparam logic [7:0] FC_READ_WRITE        = 8'd23;

    typedef struct packed {
        logic [2:0] header_bytes;
        logic [1:0] checksum_bytes;
        logic [8:0] max_frame_bytes;
        logic       receive_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [8:0] bytes_left;
        logic [8:0] frame_count;
        logic [7:0] function_code;
    } frame_state_t;

    typedef struct packed {
        logic [7:0] function_seen;
        logic [8:0] byte_position;
        logic       frame_end;
        logic       overflow_error;
    } step_result_t;

    // Number of meta bytes that follow the function byte
    function automatic logic [3:0] meta_len(input logic [7:0] fc, input logic req);
        logic [3:0] n;
        if (req) begin
            if (fc <= FC_WRITE_SINGLE_REG)
                n = 4'd4;
            else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)
                n = 4'd5;
            else if (fc == FC_MASK_WRITE)
                n = 4'd6;
            else if (fc == FC_READ_WRITE)
                n = 4'd9;
            else
                n = 4'd0;
        end
        else begin
            if (fc == FC_WRITE_SINGLE_COIL || fc == FC_WRITE_SINGLE_REG ||
                fc == FC_WRITE_COILS || fc == FC_WRITE_REGS)
                n = 4'd4;
            else if (fc == FC_MASK_WRITE)
                n = 4'd6;
            else
                n = 4'd1;
        end
        return n;
    endfunction

    // High when the last meta byte carries the data byte count
    function automatic logic data_from_meta(input logic [7:0] fc, input logic req);
        logic sel;
        if (req)
            sel = (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS) || (fc == FC_READ_WRITE);
        else
            sel = (fc <= FC_READ_INPUT_REGS) || (fc == FC_REPORT_ID) || (fc == FC_READ_WRITE);
        return sel;
    endfunction

endpackage

/* rtl/mflt_step.sv */
module mflt_step (
    input  mflt_pkg::cfg_t         cfg,
    input  mflt_pkg::frame_state_t cur,
    input  logic [7:0]             rx_byte,
    output mflt_pkg::frame_state_t nxt,
    output mflt_pkg::step_result_t res
);

    logic [8:0]  pos;
    logic [9:0]  received;
    logic [7:0]  fc;
    logic [3:0]  mlen;
    logic [8:0]  dlen;
    logic [10:0] total;
    logic        decide;
    logic        end_hit;
    logic        err_hit;
    logic [1:0]  phase_w;
    logic [8:0]  left_w;
    logic [8:0]  left_dec;

    assign pos      = cur.frame_count;
    assign received = {1'b0, pos} + 10'd1;
    assign left_dec = (cur.bytes_left != 9'd0) ? cur.bytes_left - 9'd1 : 9'd0;

    // Walk the phases for one byte
    always_comb
    begin
        fc      = cur.function_code;
        phase_w = cur.phase;
        left_w  = cur.bytes_left;
        decide  = 1'b0;
        end_hit = 1'b0;
        mlen    = 4'd0;
        unique case (cur.phase)
            mflt_pkg::PH_FUNC:
            begin
                if (pos >= {6'd0, cfg.header_bytes})
                begin
                    fc   = rx_byte;
                    mlen = mflt_pkg::meta_len(rx_byte, cfg.receive_mode);
                    if (mlen != 4'd0)
                    begin
                        phase_w = mflt_pkg::PH_META;
                        left_w  = {5'd0, mlen};
                    end
                    else
                        decide = 1'b1;
                end
            end
            mflt_pkg::PH_META:
            begin
                left_w = left_dec;
                decide = (left_dec == 9'd0);
            end
            default:
            begin
                left_w  = left_dec;
                end_hit = (left_dec == 9'd0);
            end
        endcase
    end

    // Data length and overflow check
    always_comb
    begin
        dlen = {7'd0, cfg.checksum_bytes};
        if (mflt_pkg::data_from_meta(fc, cfg.receive_mode))
            dlen = {1'b0, rx_byte} + {7'd0, cfg.checksum_bytes};
        total = {1'b0, received} + {2'd0, dlen};
    end

    always_comb
    begin
        err_hit = 1'b0;
        nxt.phase         = phase_w;
        nxt.bytes_left    = left_w;
        nxt.function_code = fc;
        res.frame_end     = end_hit;
        if (decide)
        begin
            if (total > {2'd0, cfg.max_frame_bytes})
                err_hit = 1'b1;
            else if (dlen == 9'd0)
                res.frame_end = 1'b1;
            else
            begin
                nxt.phase      = mflt_pkg::PH_DATA;
                nxt.bytes_left = dlen;
            end
        end
        res.overflow_error = err_hit;
        res.byte_position  = pos;
        res.function_seen  = fc;
        // Restart the frame after an end or an error
        if (res.frame_end || err_hit)
        begin
            nxt.phase         = mflt_pkg::PH_FUNC;
            nxt.bytes_left    = 9'd0;
            nxt.frame_count   = 9'd0;
            nxt.function_code = 8'd0;
        end
        else
            nxt.frame_count = received[8:0];
    end

endmodule

/* rtl/modbus_frame_length_tracker.sv */
// Modbus frame length tracker: one result per received byte.
// Each result is registered and appears on the master side in the cycle after the byte is taken.
// Throughput: one byte per cycle while results are taken; the frame state register updates in the accepting cycle.
// A stalled result is held in the output register; the slave side stalls only while it is full.
// Reset (rst_n low, asynchronous) empties the output register, restarts the frame and
// loads the registers with header 1, checksum 2, maximum 256 and response mode.
module modbus_frame_length_tracker (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] byte_echo, [16:8] byte_position,
                                   // [24:17] function_seen, [31:25] zero
    output logic        m_tlast,   // frame_end
    output logic        m_tuser    // overflow_error
);

    mflt_pkg::cfg_t         cfg_reg;
    mflt_pkg::frame_state_t state_reg;
    mflt_pkg::frame_state_t state_next;
    mflt_pkg::step_result_t res;
    logic                   accept;
    logic                   m_tvalid_reg;
    logic [7:0]             echo_reg;
    logic [8:0]             pos_reg;
    logic [7:0]             func_reg;
    logic                   end_reg;
    logic                   err_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mflt_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .rx_byte (s_tdata),
        .nxt     (state_next),
        .res     (res)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes    <= 3'd1;
            cfg_reg.checksum_bytes  <= 2'd2;
            cfg_reg.max_frame_bytes <= 9'd256;
            cfg_reg.receive_mode    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mflt_pkg::REG_HEADER:   cfg_reg.header_bytes    <= cfg_data[2:0];
                mflt_pkg::REG_CHECKSUM: cfg_reg.checksum_bytes  <= cfg_data[1:0];
                mflt_pkg::REG_MAX:      cfg_reg.max_frame_bytes <= cfg_data;
                mflt_pkg::REG_MODE:     cfg_reg.receive_mode    <= cfg_data[0];
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Advance frame state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= mflt_pkg::PH_FUNC;
            state_reg.bytes_left    <= 9'd0;
            state_reg.frame_count   <= 9'd0;
            state_reg.function_code <= 8'd0;
        end
        else if (accept)
            state_reg <= state_next;
    end

    // Hold the output valid until the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            echo_reg <= s_tdata;
            pos_reg  <= res.byte_position;
            func_reg <= res.function_seen;
            end_reg  <= res.frame_end;
            err_reg  <= res.overflow_error;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, func_reg, pos_reg, echo_reg};
    assign m_tlast  = end_reg;
    assign m_tuser  = err_reg;

`ifndef SYNTH
    a_end_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(end_reg && err_reg))
        else $error("frame end and overflow on the same byte");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (res.frame_end || res.overflow_error)) |=>
            (state_reg.frame_count == 9'd0 && state_reg.phase == mflt_pkg::PH_FUNC))
        else $error("frame not restarted after end or overflow");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != mflt_pkg::PH_FUNC) |-> (state_reg.bytes_left != 9'd0))
        else $error("meta or data phase with no bytes left");

    a_fresh_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.frame_count == 9'd0) |->
            (state_reg.function_code == 8'd0 && state_reg.phase == mflt_pkg::PH_FUNC))
        else $error("new frame carries stale function code or phase");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    // Kinds of entries in the stimulus stream
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_CFG,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] idx;
        logic [8:0] data;
    } stream_cmd_t;

    typedef struct packed {
        logic [7:0] echo;
        logic [8:0] position;
        logic [7:0] func;
        logic       ends;
        logic       ovf;
    } byte_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [7:0] byte_echo, [16:8] byte_position,
                                   // [24:17] function_seen, [31:25] zero
    logic        m_tlast;          // frame_end
    logic        m_tuser;          // overflow_error

    stream_cmd_t  rx_stream[$];
    byte_result_t predicted_bytes[$];
    int           bytes_in_flight = 0;
    int           mismatch_count  = 0;

    int src_gap   = 0;
    int src_quiet = 0;
    int dst_hold  = 0;
    int dst_quiet = 0;

    // Tracker copy: registers
    logic [2:0] hdr_r  = 3'd1;
    logic [1:0] cks_r  = 2'd2;
    logic [8:0] max_r  = 9'd256;
    logic       mode_r = 1'b0;

    // Tracker copy: frame state
    logic [1:0] phase_r   = mflt_pkg::PH_FUNC;
    logic [8:0] left_r    = '0;
    logic [8:0] frame_cnt = '0;
    logic [7:0] fcode_r   = '0;

    // Register values as the stimulus stream will leave them
    logic [2:0] gen_hdr  = 3'd1;
    logic [1:0] gen_cks  = 2'd2;
    logic [8:0] gen_max  = 9'd256;
    logic       gen_mode = 1'b0;
    int         gen_bytes = 0;

    modbus_frame_length_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Meta bytes that follow the function byte
    function automatic int meta_count(input logic [7:0] fc, input logic req);
        if (req)
        begin
            if (fc <= mflt_pkg::FC_WRITE_SINGLE_REG) return 4;
            if (fc == mflt_pkg::FC_WRITE_COILS || fc == mflt_pkg::FC_WRITE_REGS) return 5;
            if (fc == mflt_pkg::FC_MASK_WRITE) return 6;
            if (fc == mflt_pkg::FC_READ_WRITE) return 9;
            return 0;
        end
        if (fc == mflt_pkg::FC_WRITE_SINGLE_COIL || fc == mflt_pkg::FC_WRITE_SINGLE_REG ||
            fc == mflt_pkg::FC_WRITE_COILS || fc == mflt_pkg::FC_WRITE_REGS)
            return 4;
        if (fc == mflt_pkg::FC_MASK_WRITE) return 6;
        return 1;
    endfunction

    // Data bytes plus checksum once the last meta byte is known
    function automatic int data_count(input logic [7:0] fc, input logic req,
                                      input logic [7:0] count, input logic [1:0] cks);
        logic takes;
        if (req)
            takes = (fc == mflt_pkg::FC_WRITE_COILS) || (fc == mflt_pkg::FC_WRITE_REGS) ||
                    (fc == mflt_pkg::FC_READ_WRITE);
        else
            takes = (fc <= mflt_pkg::FC_READ_INPUT_REGS) || (fc == mflt_pkg::FC_REPORT_ID) ||
                    (fc == mflt_pkg::FC_READ_WRITE);
        return (takes ? int'(count) : 0) + int'(cks);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the frame state by one byte and produce its result
    task automatic track_frame_byte(input logic [7:0] b, output byte_result_t r);
        int   pos;
        int   received;
        int   m;
        int   d;
        logic decide;
        logic done;
        logic ovf;
        pos      = int'(frame_cnt);
        received = pos + 1;
        decide   = 1'b0;
        done     = 1'b0;
        ovf      = 1'b0;
        case (phase_r)
            mflt_pkg::PH_FUNC:
            begin
                if (pos >= int'(hdr_r))
                begin
                    fcode_r = b;
                    m = meta_count(b, mode_r);
                    if (m != 0)
                    begin
                        phase_r = mflt_pkg::PH_META;
                        left_r  = 9'(m);
                    end
                    else
                        decide = 1'b1;
                end
            end
            mflt_pkg::PH_META:
            begin
                if (left_r != 9'd0) left_r = left_r - 9'd1;
                if (left_r == 9'd0) decide = 1'b1;
            end
            default:
            begin
                if (left_r != 9'd0) left_r = left_r - 9'd1;
                if (left_r == 9'd0) done = 1'b1;
            end
        endcase
        // length check when the data count is settled
        if (decide)
        begin
            d = data_count(fcode_r, mode_r, b, cks_r);
            if (received + d > int'(max_r))
                ovf = 1'b1;
            else if (d == 0)
                done = 1'b1;
            else
            begin
                phase_r = mflt_pkg::PH_DATA;
                left_r  = 9'(d);
            end
        end
        r.echo     = b;
        r.position = 9'(pos);
        r.func     = fcode_r;
        r.ends     = done;
        r.ovf      = ovf;
        if (done || ovf)
        begin
            phase_r   = mflt_pkg::PH_FUNC;
            left_r    = '0;
            frame_cnt = '0;
            fcode_r   = '0;
        end
        else
            frame_cnt = 9'(received);
    endtask

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
            mismatch_count++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_cmd_t c;
        c.kind = CMD_BYTE;
        c.idx  = '0;
        c.data = {1'b0, b};
        rx_stream.push_back(c);
        gen_bytes++;
    endtask

    task automatic push_drain();
        stream_cmd_t c;
        c.kind = CMD_DRAIN;
        c.idx  = '0;
        c.data = '0;
        rx_stream.push_back(c);
    endtask

    task automatic push_cfg(input logic [1:0] idx, input logic [8:0] val);
        stream_cmd_t c;
        c.kind = CMD_CFG;
        c.idx  = idx;
        c.data = val;
        rx_stream.push_back(c);
        case (idx)
            mflt_pkg::REG_HEADER:   gen_hdr  = val[2:0];
            mflt_pkg::REG_CHECKSUM: gen_cks  = val[1:0];
            mflt_pkg::REG_MAX:      gen_max  = val;
            default:                gen_mode = val[0];
        endcase
    endtask

    // Pick one register and a value for it, extremes included
    task automatic push_random_register();
        int         r;
        logic [1:0] idx;
        logic [8:0] val;
        idx = 2'($urandom_range(0, 3));
        r   = $urandom_range(0, 15);
        case (idx)
            mflt_pkg::REG_HEADER:
                val = (r < 4) ? 9'd0 : (r < 8) ? 9'd1 : (r < 10) ? 9'd7 :
                      9'($urandom_range(0, 511));
            mflt_pkg::REG_CHECKSUM:
                val = (r < 12) ? 9'($urandom_range(0, 3)) : 9'($urandom_range(0, 511));
            mflt_pkg::REG_MAX:
                val = (r == 0) ? 9'd0 : (r == 1) ? 9'd1 : (r == 2) ? 9'd260 :
                      (r == 3) ? 9'd511 : (r < 6) ? 9'($urandom_range(2, 40)) :
                      (r < 10) ? 9'd256 : 9'($urandom_range(100, 511));
            default:
                val = (r < 12) ? 9'($urandom_range(0, 1)) : 9'($urandom_range(0, 511));
        endcase
        push_cfg(idx, val);
    endtask

    function automatic logic [7:0] pick_function();
        case ($urandom_range(0, 15))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd3;
            3:       return mflt_pkg::FC_READ_INPUT_REGS;
            4:       return mflt_pkg::FC_WRITE_SINGLE_COIL;
            5:       return mflt_pkg::FC_WRITE_SINGLE_REG;
            6:       return mflt_pkg::FC_WRITE_COILS;
            7:       return mflt_pkg::FC_WRITE_REGS;
            8:       return mflt_pkg::FC_REPORT_ID;
            9:       return mflt_pkg::FC_MASK_WRITE;
            10:      return mflt_pkg::FC_READ_WRITE;
            11:      return 8'($urandom_range(7, 14));
            12:      return 8'($urandom_range(0, 30));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one frame laid out for the registers in force, optionally cut short or split by a register write
    task automatic push_frame(input logic cut);
        logic [7:0] frame_q[$];
        logic [7:0] fc;
        logic [7:0] count;
        int         m;
        int         d;
        int         keep;
        int         split;
        fc    = pick_function();
        m     = meta_count(fc, gen_mode);
        count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                              8'($urandom_range(0, 16));
        d     = data_count(fc, gen_mode, count, gen_cks);
        for (int i = 0; i < int'(gen_hdr); i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
        frame_q.push_back(fc);
        for (int i = 0; i < m; i++)
            frame_q.push_back((i == m - 1) ? count : 8'($urandom_range(0, 255)));
        // stop at the decision byte when the frame is too long
        if (frame_q.size() + d <= int'(gen_max))
            for (int i = 0; i < d; i++)
                frame_q.push_back(8'($urandom_range(0, 255)));
        keep = frame_q.size();
        if (cut && keep > 1)
            keep = $urandom_range(1, keep - 1);
        split = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, keep - 1)) : -1;
        for (int i = 0; i < keep; i++)
        begin
            if (i == split)
                push_random_register();
            push_byte(frame_q[i]);
        end
    endtask

    // Feed requests from the stream; registers change only with nothing in flight
    always @(posedge clk)
    begin : drive_requests
        logic       nv;
        logic [7:0] nbyte;
        logic       nwe;
        logic [1:0] nidx;
        logic [8:0] ndat;
        int         ngap;
        int         nquiet;
        logic       idle;
        nv     = s_tvalid;
        nbyte  = s_tdata;
        nwe    = 1'b0;
        nidx   = cfg_index;
        ndat   = cfg_data;
        ngap   = src_gap;
        nquiet = src_quiet;
        idle   = !s_tvalid && bytes_in_flight == 0;
        if (rst_n && !(s_tvalid && !s_tready))
        begin
            nv = 1'b0;
            if (ngap != 0)
                ngap--;
            else if (rx_stream.size() != 0)
            begin
                case (rx_stream[0].kind)
                    CMD_BYTE:
                    begin
                        nv    = 1'b1;
                        nbyte = rx_stream[0].data[7:0];
                        rx_stream.delete(0);
                        if (nquiet != 0)
                        begin
                            nquiet--;
                            ngap = 0;
                        end
                        else
                        begin
                            ngap = draw_gap();
                            if ($urandom_range(0, 99) < 3)
                                nquiet = $urandom_range(20, 80);
                        end
                    end
                    CMD_CFG:
                    begin
                        if (idle)
                        begin
                            nwe  = 1'b1;
                            nidx = rx_stream[0].idx;
                            ndat = rx_stream[0].data;
                            rx_stream.delete(0);
                        end
                    end
                    default:
                    begin
                        if (idle)
                            rx_stream.delete(0);
                    end
                endcase
            end
        end
        s_tvalid  <= nv;
        s_tdata   <= nbyte;
        cfg_we    <= nwe;
        cfg_index <= nidx;
        cfg_data  <= ndat;
        src_gap   <= ngap;
        src_quiet <= nquiet;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin : pace_results
        logic rdy;
        int   hold;
        int   quiet;
        rdy   = m_tready;
        hold  = dst_hold;
        quiet = dst_quiet;
        if (rst_n)
        begin
            if (hold != 0)
            begin
                rdy = 1'b0;
                hold--;
            end
            else if (m_tvalid && m_tready)
            begin
                if (quiet != 0)
                begin
                    quiet--;
                    rdy = 1'b1;
                end
                else
                begin
                    hold = draw_gap();
                    if ($urandom_range(0, 99) < 3)
                        quiet = $urandom_range(20, 80);
                    rdy = (hold == 0);
                    if (hold != 0)
                        hold--;
                end
            end
            else
                rdy = 1'b1;
        end
        m_tready  <= rdy;
        dst_hold  <= hold;
        dst_quiet <= quiet;
    end

    // Check each result, then predict the request taken at this edge
    always @(posedge clk)
    begin : watch_results
        byte_result_t want;
        int           delta;
        delta = 0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none got tdata %h last %b user %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_bytes.pop_front();
                    delta--;
                    check_field("byte_echo", int'(want.echo), int'(m_tdata[7:0]));
                    check_field("byte_position", int'(want.position), int'(m_tdata[16:8]));
                    check_field("function_seen", int'(want.func), int'(m_tdata[24:17]));
                    check_field("frame_end", int'(want.ends), int'(m_tlast));
                    check_field("overflow_error", int'(want.ovf), int'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
            begin
                track_frame_byte(s_tdata, want);
                predicted_bytes.push_back(want);
                delta++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    mflt_pkg::REG_HEADER:   hdr_r  = cfg_data[2:0];
                    mflt_pkg::REG_CHECKSUM: cks_r  = cfg_data[1:0];
                    mflt_pkg::REG_MAX:      max_r  = cfg_data;
                    default:                mode_r = cfg_data[0];
                endcase
            end
        end
        bytes_in_flight <= bytes_in_flight + delta;
    end

    initial
    begin
        int r;

        // response read: header, function, byte count, two data bytes, checksum
        push_byte(8'h00);
        push_byte(8'h03);
        push_byte(8'h02);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h11);
        push_byte(8'h22);

        // request with no meta bytes and no checksum ends on the function byte
        push_cfg(mflt_pkg::REG_MODE, 9'd1);
        push_cfg(mflt_pkg::REG_CHECKSUM, 9'd0);
        push_cfg(mflt_pkg::REG_HEADER, 9'd0);
        push_byte(8'h41);

        // too long for the maximum: abandon at the byte count
        push_cfg(mflt_pkg::REG_MAX, 9'd3);
        push_byte(mflt_pkg::FC_WRITE_REGS);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h04);
        push_drain();

        // lower the header length mid-frame, then switch mode before the decision
        push_cfg(mflt_pkg::REG_MAX, 9'd511);
        push_cfg(mflt_pkg::REG_HEADER, 9'd3);
        push_cfg(mflt_pkg::REG_CHECKSUM, 9'd3);
        push_byte(8'hA5);
        push_byte(8'h5A);
        push_cfg(mflt_pkg::REG_HEADER, 9'd1);
        push_byte(mflt_pkg::FC_WRITE_SINGLE_COIL);
        push_byte(8'h00);
        push_byte(8'h01);
        push_cfg(mflt_pkg::REG_MODE, 9'd0);
        push_byte(8'h02);
        push_byte(8'h07);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);

        // back to reset values for the random part
        push_cfg(mflt_pkg::REG_HEADER, 9'd1);
        push_cfg(mflt_pkg::REG_CHECKSUM, 9'd2);
        push_cfg(mflt_pkg::REG_MAX, 9'd256);
        push_cfg(mflt_pkg::REG_MODE, 9'd0);

        while (gen_bytes < 1350)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_random_register();
            else if (r < 7)
                push_drain();
            else if (r < 80)
                push_frame(1'b0);
            else if (r < 90)
                push_frame(1'b1);
            else
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the stream to empty and every result to come back
        while (rx_stream.size() != 0 || s_tvalid || bytes_in_flight != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (predicted_bytes.size() != 0)
        begin
            $display("%0t: %0d results expected, none arrived", $time, predicted_bytes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
